[sv/dtwa_pkg.sv]
// dtwa_pkg: shared types and constants for the device table with aging
// no dependencies; used by device_table_with_aging_core
package dtwa_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [8:0]  ALPHA_RESET   = 9'd77;
   localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
   localparam logic [8:0]  ALPHA_ONE     = 9'd256;
   localparam logic [15:0] SEEN_MAX      = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_OBSERVE   = 2'd0,
      CMD_SWEEP     = 2'd1,
      CMD_WHITELIST = 2'd2,
      CMD_READ      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_MERGED    = 3'd0,
      ST_ADDED     = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_WL_SET    = 3'd4,
      ST_SWEPT     = 3'd5,
      ST_READ_OK   = 3'd6
   } status_type;

   typedef enum logic {
      REG_ALPHA   = 1'b0,
      REG_TIMEOUT = 1'b1
   } reg_type;

   // one table entry as held in the memory
   typedef struct packed {
      logic [47:0] address;
      logic [1:0]  protocol;
      logic [7:0]  channel;
      logic [7:0]  last_rssi;
      logic [7:0]  avg_rssi;
      logic [31:0] first_ms;
      logic [31:0] last_ms;
      logic        whitelisted;
      logic [15:0] seen_count;
   } entry_type;

endpackage

[sv/device_table_with_aging_core.sv]
// device_table_with_aging_core: device table with smoothed rssi and stale sweep
// state in one synchronous entry memory; depends on dtwa_pkg
// observe/whitelist compare one stored key a cycle over the n entries in use; a read
//   of a slot at or past count answers not found; sweep moves the last entry into each dropped
//   slot; finish waits while rsp_tready stalls; one item at a time, input ready only in idle
// reset is synchronous and empties the table; memory is not cleared, never read past count
module device_table_with_aging_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0]
   input  logic [1:0]   req_tuser,
   // address[47:0] protocol[49:48] channel[57:50] rssi[65:58] now_ms[97:66]
   // whitelist_flag[98] read_slot[103:99]
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0]
   output logic [2:0]   rsp_tuser,
   // slot[5:0] entries_in_use[11:6] entry_address[59:12] entry_protocol[61:60]
   // entry_channel[69:62] last_rssi[77:70] avg_rssi[85:78]
   // first_ms[117:86] last_ms[149:118] seen_count[165:150]
   // whitelisted[166] zero pad[167]
   output logic [167:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int IDX_W = dtwa_pkg::IDX_W;
   localparam int CNT_W = dtwa_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_UPDATE, S_RDREQ, S_RDDATA,
      S_SW_RD, S_SW_CHK, S_SW_MOVE, S_FIN
   } state_type;

   state_type            state_ff;
   logic [8:0]           alpha_ff;
   logic [31:0]          timeout_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     scan_ff;
   logic                 cmp_vld_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic [CNT_W-1:0]     dropped_ff;

   dtwa_pkg::cmd_type    cmd_ff;
   logic [47:0]          addr_ff;
   logic [1:0]           proto_ff;
   logic [7:0]           chan_ff;
   logic [7:0]           rssi_ff;
   logic [31:0]          now_ff;
   logic                 wl_ff;
   logic [4:0]           rslot_ff;

   dtwa_pkg::status_type res_status_ff;
   logic [CNT_W-1:0]     res_slot_ff;
   dtwa_pkg::entry_type  res_entry_ff;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_user_ff;
   logic [167:0]         rsp_data_ff;

   dtwa_pkg::entry_type  table_mem [dtwa_pkg::TABLE_DEPTH];
   dtwa_pkg::entry_type  rdata_ff;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   dtwa_pkg::entry_type  wdata;

   logic                 cfg_wr;
   logic                 accept;
   logic                 match;
   logic                 hit;
   logic                 scan_more;
   logic                 room;
   logic                 stale;
   logic                 rs_ok;
   logic [31:0]          age;
   logic [8:0]           a_sat;
   logic [8:0]           w_old;
   logic signed [17:0]   p_old;
   logic signed [17:0]   p_new;
   logic signed [18:0]   sum;
   logic signed [18:0]   sum_adj;
   logic [7:0]           sm;
   logic [15:0]          seen_inc;
   dtwa_pkg::entry_type  new_entry;
   dtwa_pkg::entry_type  upd_entry;

   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == dtwa_pkg::REG_TIMEOUT) ? timeout_ff
                                                               : {23'd0, alpha_ff};

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign match     = cmp_vld_ff && (rdata_ff.address == addr_ff)
                      && (rdata_ff.protocol == proto_ff);
   assign scan_more = (scan_ff < count_ff);
   assign hit       = match;
   assign room      = (count_ff < CNT_W'(dtwa_pkg::TABLE_DEPTH));
   assign rs_ok     = ({{(CNT_W > 5 ? CNT_W - 5 : 0){1'b0}}, rslot_ff} < count_ff);
   assign age       = now_ff - rdata_ff.last_ms;
   assign stale     = (age >= timeout_ff);

   // q8 smoothing, truncated toward zero
   always_comb begin
      a_sat    = (alpha_ff > dtwa_pkg::ALPHA_ONE) ? dtwa_pkg::ALPHA_ONE : alpha_ff;
      w_old    = dtwa_pkg::ALPHA_ONE - a_sat;
      p_old    = $signed({1'b0, w_old}) * $signed(rdata_ff.avg_rssi);
      p_new    = $signed({1'b0, a_sat}) * $signed(rssi_ff);
      sum      = 19'(p_old) + 19'(p_new);
      sum_adj  = sum + ((sum < 0) ? 19'sd255 : 19'sd0);
      sm       = sum_adj[15:8];
      seen_inc = (rdata_ff.seen_count != dtwa_pkg::SEEN_MAX) ?
                 rdata_ff.seen_count + 16'd1 : rdata_ff.seen_count;

      upd_entry            = rdata_ff;
      upd_entry.channel    = chan_ff;
      upd_entry.last_rssi  = rssi_ff;
      upd_entry.avg_rssi   = sm;
      upd_entry.last_ms    = now_ff;
      upd_entry.seen_count = seen_inc;
      if (cmd_ff == dtwa_pkg::CMD_WHITELIST) begin
         upd_entry             = rdata_ff;
         upd_entry.whitelisted = wl_ff;
      end

      new_entry.address     = addr_ff;
      new_entry.protocol    = proto_ff;
      new_entry.channel     = chan_ff;
      new_entry.last_rssi   = rssi_ff;
      new_entry.avg_rssi    = rssi_ff;
      new_entry.first_ms    = now_ff;
      new_entry.last_ms     = now_ff;
      new_entry.whitelisted = 1'b0;
      new_entry.seen_count  = 16'd1;
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = cmp_idx_ff;
      wdata   = upd_entry;
      unique case (state_ff)
         S_SEARCH: begin
            if (!hit && scan_more) begin
               rd_en = 1'b1;
            end else if (!hit && cmd_ff == dtwa_pkg::CMD_OBSERVE && room) begin
               wr_en   = 1'b1;
               wr_addr = count_ff[IDX_W-1:0];
               wdata   = new_entry;
            end
         end
         S_UPDATE: begin
            wr_en = 1'b1;
         end
         S_RDREQ: begin
            rd_en   = rs_ok;
            rd_addr = rslot_ff;
         end
         S_SW_RD: begin
            rd_en = scan_more;
         end
         S_SW_CHK: begin
            rd_en   = stale;
            rd_addr = IDX_W'(count_ff - CNT_W'(1));
         end
         S_SW_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[IDX_W-1:0];
            wdata   = rdata_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alpha_ff     <= dtwa_pkg::ALPHA_RESET;
         timeout_ff   <= dtwa_pkg::TIMEOUT_RESET;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            if (csr_paddr[2] == dtwa_pkg::REG_TIMEOUT) begin
               timeout_ff <= csr_pwdata;
            end else begin
               alpha_ff <= csr_pwdata[8:0];
            end
         end
         // a beat loaded in the finish state takes the place of the one leaving
         if (rsp_valid_ff && rsp_tready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff     <= dtwa_pkg::cmd_type'(req_tuser);
                  addr_ff    <= req_tdata[47:0];
                  proto_ff   <= req_tdata[49:48];
                  chan_ff    <= req_tdata[57:50];
                  rssi_ff    <= req_tdata[65:58];
                  now_ff     <= req_tdata[97:66];
                  wl_ff      <= req_tdata[98];
                  rslot_ff   <= req_tdata[103:99];
                  scan_ff    <= '0;
                  dropped_ff <= '0;
                  cmp_vld_ff <= 1'b0;
                  res_entry_ff <= '0;
                  res_slot_ff  <= '0;
                  unique case (dtwa_pkg::cmd_type'(req_tuser))
                     dtwa_pkg::CMD_SWEEP: state_ff <= S_SW_RD;
                     dtwa_pkg::CMD_READ:  state_ff <= S_RDREQ;
                     default:             state_ff <= S_SEARCH;
                  endcase
               end
            end
            S_SEARCH: begin
               if (hit) begin
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= S_UPDATE;
               end else if (scan_more) begin
                  cmp_vld_ff <= 1'b1;
                  cmp_idx_ff <= scan_ff[IDX_W-1:0];
                  scan_ff    <= scan_ff + CNT_W'(1);
               end else begin
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= S_FIN;
                  if (cmd_ff == dtwa_pkg::CMD_OBSERVE && room) begin
                     count_ff      <= count_ff + CNT_W'(1);
                     res_status_ff <= dtwa_pkg::ST_ADDED;
                     res_slot_ff   <= count_ff;
                     res_entry_ff  <= new_entry;
                  end else if (cmd_ff == dtwa_pkg::CMD_OBSERVE) begin
                     res_status_ff <= dtwa_pkg::ST_FULL;
                  end else begin
                     res_status_ff <= dtwa_pkg::ST_NOT_FOUND;
                  end
               end
            end
            S_UPDATE: begin
               res_status_ff <= (cmd_ff == dtwa_pkg::CMD_OBSERVE) ?
                                dtwa_pkg::ST_MERGED : dtwa_pkg::ST_WL_SET;
               res_slot_ff   <= CNT_W'(cmp_idx_ff);
               res_entry_ff  <= upd_entry;
               state_ff      <= S_FIN;
            end
            S_RDREQ: begin
               if (rs_ok) begin
                  state_ff <= S_RDDATA;
               end else begin
                  res_status_ff <= dtwa_pkg::ST_NOT_FOUND;
                  state_ff      <= S_FIN;
               end
            end
            S_RDDATA: begin
               res_status_ff <= dtwa_pkg::ST_READ_OK;
               res_slot_ff   <= CNT_W'(rslot_ff);
               res_entry_ff  <= rdata_ff;
               state_ff      <= S_FIN;
            end
            S_SW_RD: begin
               if (scan_more) begin
                  state_ff <= S_SW_CHK;
               end else begin
                  res_status_ff <= dtwa_pkg::ST_SWEPT;
                  res_slot_ff   <= dropped_ff;
                  state_ff      <= S_FIN;
               end
            end
            S_SW_CHK: begin
               if (stale) begin
                  state_ff <= S_SW_MOVE;
               end else begin
                  scan_ff  <= scan_ff + CNT_W'(1);
                  state_ff <= S_SW_RD;
               end
            end
            S_SW_MOVE: begin
               // last entry fills the hole, same slot is checked again
               count_ff   <= count_ff - CNT_W'(1);
               dropped_ff <= dropped_ff + CNT_W'(1);
               state_ff   <= S_SW_RD;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= res_status_ff;
                  rsp_data_ff  <= {1'b0, res_entry_ff.whitelisted,
                                   res_entry_ff.seen_count,
                                   res_entry_ff.last_ms,
                                   res_entry_ff.first_ms,
                                   res_entry_ff.avg_rssi,
                                   res_entry_ff.last_rssi,
                                   res_entry_ff.channel,
                                   res_entry_ff.protocol,
                                   res_entry_ff.address,
                                   6'(count_ff), 6'(res_slot_ff)};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(dtwa_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("memory read and write in one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted item did not start");

   a_sweep_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SW_MOVE |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("sweep move did not drop an entry");

endmodule
